>>> hw/rtl/bgb_pkg.sv
// Shared types, constants and the microcode ROM of the bitmap glyph blitter.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package bgb_pkg;

	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 8;
	localparam int GLYPH_COUNT  = 256;
	localparam int ROW_STRIDE   = 8;
	localparam int STORE_DEPTH  = 2048;
	localparam int STORE_AW     = 11;

	// Operation codes of the input channel.
	localparam logic OP_DRAW      = 1'b0;
	localparam logic OP_FONT_ROW  = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [2:0] REG_CLIP_RIGHT  = 3'd2;
	localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [2:0] REG_WIDE_PIXELS = 3'd4;
	localparam logic [2:0] REG_BACK_ROW    = 3'd5;

	typedef struct packed {
		logic [10:0] clip_left;
		logic [10:0] clip_top;
		logic [10:0] clip_right;
		logic [10:0] clip_bottom;
		logic        wide_pixels;
		logic [10:0] back_buffer_row;
	} cfg_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_READ   = 3'd1;
	localparam step_t STEP_LOAD   = 3'd2;
	localparam step_t STEP_SCAN   = 3'd3;
	localparam step_t STEP_ROWEND = 3'd4;
	localparam step_t STEP_FLUSH  = 3'd5;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_START,
		COND_COL_LAST,
		COND_ROW_LAST
	} cond_t;

	typedef struct packed {
		logic  in_rdy;
		logic  mem_rd;
		logic  load_line;
		logic  scan;
		logic  row_step;
		logic  flush;
		cond_t cond;
		step_t nxt_t;
		step_t nxt_f;
	} ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic start;
		logic col_last;
		logic row_last;
		logic stall;
		logic pend_valid;
	} stat_t;

	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		w = '0;
		w.cond  = COND_ALWAYS;
		w.nxt_t = STEP_IDLE;
		w.nxt_f = STEP_IDLE;
		case (step)
			STEP_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond   = COND_START;
				w.nxt_t  = STEP_READ;
				w.nxt_f  = STEP_IDLE;
			end
			STEP_READ: begin
				w.mem_rd = 1'b1;
				w.nxt_t  = STEP_LOAD;
			end
			STEP_LOAD: begin
				w.load_line = 1'b1;
				w.nxt_t     = STEP_SCAN;
			end
			STEP_SCAN: begin
				w.scan  = 1'b1;
				w.cond  = COND_COL_LAST;
				w.nxt_t = STEP_ROWEND;
				w.nxt_f = STEP_SCAN;
			end
			STEP_ROWEND: begin
				w.row_step = 1'b1;
				w.cond     = COND_ROW_LAST;
				w.nxt_t    = STEP_FLUSH;
				w.nxt_f    = STEP_READ;
			end
			STEP_FLUSH: begin
				w.flush = 1'b1;
				w.nxt_t = STEP_IDLE;
			end
			default: begin
				w.nxt_t = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bgb_font_mem.sv
// Font store of the glyph blitter: one write port, one registered read port.
// Depends on bgb_pkg for the store depth and address width.
`default_nettype none

module bgb_font_mem
	import bgb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [STORE_AW-1:0] waddr,
	input  wire logic [7:0]          wdata,
	input  wire logic                re,
	input  wire logic [STORE_AW-1:0] raddr,
	output logic      [7:0]          rdata
);

	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bgb_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on bgb_pkg for the control word, status struct and ROM.
`default_nettype none

module bgb_sequencer
	import bgb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	step_t step_q;
	logic  cond_ok;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		case (ctrl.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_START:    cond_ok = stat.start;
			COND_COL_LAST: cond_ok = stat.col_last;
			COND_ROW_LAST: cond_ok = stat.row_last;
			default:       cond_ok = 1'b1;
		endcase
	end

	// A stalled step repeats until the output register can take its pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (!stat.stall) begin
			step_q <= cond_ok ? ctrl.nxt_t : ctrl.nxt_f;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bgb_datapath.sv
// Datapath of the glyph blitter: clip test, row and column counters, bit scan,
// one pending pixel for the last flag, and the output register.
// Depends on bgb_pkg; driven by the control word of bgb_sequencer.
`default_nettype none

module bgb_datapath
	import bgb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_t               ctrl,
	input  wire cfg_t                cfg,
	output stat_t                    stat,
	input  wire logic                in_valid,
	input  wire logic                operation,
	input  wire logic signed [11:0]  pos_x,
	input  wire logic signed [11:0]  pos_y,
	input  wire logic [7:0]          char_code,
	input  wire logic [15:0]         color,
	input  wire logic [10:0]         font_row_index,
	input  wire logic [7:0]          font_row_bits,
	output logic                     mem_we,
	output logic [STORE_AW-1:0]      mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic                     mem_re,
	output logic [STORE_AW-1:0]      mem_raddr,
	input  wire logic [7:0]          mem_rdata,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [12:0]       pixel_row,
	output logic signed [12:0]       pixel_column,
	output logic [15:0]              pixel_value,
	output logic                     last
);

	logic        accept;
	logic        visible;
	logic [13:0] xs, ys;

	logic [11:0] x_q, y_q;
	logic [7:0]  ch_q;
	logic [15:0] pix_q;
	logic [2:0]  row_q, col_q;
	logic [7:0]  line_q;

	logic        pend_v_q;
	logic [12:0] pend_row_q, pend_col_q;

	logic        out_valid_q, out_last_q;
	logic [12:0] out_row_q, out_col_q;
	logic [15:0] out_val_q;

	logic        out_busy, hit, stall, scan_go, flush_go;
	logic [12:0] new_row, new_col;

	assign accept = in_valid && ctrl.in_rdy;
	assign xs     = {{2{pos_x[11]}}, pos_x};
	assign ys     = {{2{pos_y[11]}}, pos_y};

	// A glyph touching the clip window at all is drawn whole.
	assign visible = ({1'b0, char_code} < 9'(GLYPH_COUNT))
		&& !($signed(xs) > $signed({3'b000, cfg.clip_right}))
		&& !($signed(ys) > $signed({3'b000, cfg.clip_bottom}))
		&& !($signed(xs + 14'(GLYPH_WIDTH - 1)) < $signed({3'b000, cfg.clip_left}))
		&& !($signed(ys + 14'(GLYPH_HEIGHT - 1)) < $signed({3'b000, cfg.clip_top}));

	assign mem_we    = accept && (operation == OP_FONT_ROW)
		&& ({1'b0, font_row_index} < 12'(GLYPH_COUNT * ROW_STRIDE));
	assign mem_waddr = font_row_index;
	assign mem_wdata = font_row_bits;
	assign mem_re    = ctrl.mem_rd;
	assign mem_raddr = {ch_q, row_q};

	assign out_busy = out_valid_q && !out_ready;
	assign hit      = ctrl.scan && line_q[7];
	assign stall    = (hit || ctrl.flush) && pend_v_q && out_busy;
	assign scan_go  = ctrl.scan && !stall;
	assign flush_go = ctrl.flush && !stall && pend_v_q;

	assign new_row = {y_q[11], y_q} + {2'b00, cfg.back_buffer_row} + {10'd0, row_q};
	assign new_col = {x_q[11], x_q} + {10'd0, col_q};

	assign stat.start      = accept && (operation == OP_DRAW) && visible;
	assign stat.col_last   = (col_q == 3'(GLYPH_WIDTH - 1));
	assign stat.row_last   = (row_q == 3'(GLYPH_HEIGHT - 1));
	assign stat.stall      = stall;
	assign stat.pend_valid = pend_v_q;

	always_ff @(posedge clk) begin
		if (stat.start) begin
			x_q   <= pos_x;
			y_q   <= pos_y;
			ch_q  <= char_code;
			pix_q <= cfg.wide_pixels ? color : {8'h00, color[7:0]};
		end
		if (ctrl.load_line) begin
			line_q <= mem_rdata;
		end else if (scan_go) begin
			line_q <= {line_q[6:0], 1'b0};
		end
		if (hit && !stall) begin
			pend_row_q <= new_row;
			pend_col_q <= new_col;
		end
		// A set bit pushes the previous pixel out; the flush step marks the last one.
		if ((hit && !stall && pend_v_q) || flush_go) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_val_q  <= pix_q;
			out_last_q <= flush_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (stat.start) begin
				row_q <= '0;
			end else if (ctrl.row_step) begin
				row_q <= row_q + 3'd1;
			end
			if (ctrl.load_line) begin
				col_q <= '0;
			end else if (scan_go) begin
				col_q <= col_q + 3'd1;
			end
			if (hit && !stall) begin
				pend_v_q <= 1'b1;
			end else if (flush_go) begin
				pend_v_q <= 1'b0;
			end
			if ((hit && !stall && pend_v_q) || flush_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_row    = out_row_q;
	assign pixel_column = out_col_q;
	assign pixel_value  = out_val_q;
	assign last         = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_glyph_blitter.sv
// Top level of the 8x8 bitmap glyph blitter: configuration registers and the
// sequencer, datapath and font store. Depends on bgb_pkg and the bgb_* modules.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    operation pos_x pos_y char_code color
//                                            font_row_index font_row_bits
//   out      output     out_valid/out_ready  pixel_row pixel_column pixel_value last
//   cfg      input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// A font-row write or a clipped glyph is taken in the idle step. For a drawn glyph,
// each row costs a font store read, a load, a bit scan over its columns and a row
// step; a flush step then pushes out the pending pixel, if any, as the last one.
// A full output register holds a scan step or the flush step only when a waiting
// pixel must be pushed out; such a stall holds the step until out_ready is seen.
// Reset (arst_n, asynchronous) clears control state and the configuration to
// its defaults; the font store is not cleared. cfg_ready is always high.
`default_nettype none

module bitmap_glyph_blitter
	import bgb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic signed [11:0] pos_x,
	input  wire logic signed [11:0] pos_y,
	input  wire logic [7:0]         char_code,
	input  wire logic [15:0]        color,
	input  wire logic [10:0]        font_row_index,
	input  wire logic [7:0]         font_row_bits,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [12:0]      pixel_row,
	output logic signed [12:0]      pixel_column,
	output logic [15:0]             pixel_value,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [10:0]        cfg_data
);

	cfg_t                cfg_q;
	ctrl_t               ctrl;
	stat_t               stat;
	logic                mem_we, mem_re;
	logic [STORE_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]          mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = ctrl.in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left       <= 11'd0;
			cfg_q.clip_top        <= 11'd0;
			cfg_q.clip_right      <= 11'd639;
			cfg_q.clip_bottom     <= 11'd479;
			cfg_q.wide_pixels     <= 1'b1;
			cfg_q.back_buffer_row <= 11'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLIP_LEFT:   cfg_q.clip_left       <= cfg_data;
				REG_CLIP_TOP:    cfg_q.clip_top        <= cfg_data;
				REG_CLIP_RIGHT:  cfg_q.clip_right      <= cfg_data;
				REG_CLIP_BOTTOM: cfg_q.clip_bottom     <= cfg_data;
				REG_WIDE_PIXELS: cfg_q.wide_pixels     <= cfg_data[0];
				REG_BACK_ROW:    cfg_q.back_buffer_row <= cfg_data;
				default: ;
			endcase
		end
	end

	bgb_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bgb_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.cfg            (cfg_q),
		.stat           (stat),
		.in_valid       (in_valid),
		.operation      (operation),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.char_code      (char_code),
		.color          (color),
		.font_row_index (font_row_index),
		.font_row_bits  (font_row_bits),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_row      (pixel_row),
		.pixel_column   (pixel_column),
		.pixel_value    (pixel_value),
		.last           (last)
	);

	bgb_font_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// No pixel may be left pending once the block takes a new item.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pend_valid)
		else $error("pending pixel while idle");

	// The font store is never written and read in the same cycle.
	a_mem_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("font store written and read together");

	// A font-row transfer leaves the block idle for the next item.
	a_font_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_FONT_ROW) |=> in_ready)
		else $error("font-row write left the idle step");

	// A last pixel is only loaded by the flush step.
	a_last_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && last) |-> $past(ctrl.flush))
		else $error("last flag outside flush step");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_glyph_blitter: loads glyph rows and draws them
// under several clip windows, checking every pixel write against a local predictor or directed expected writes.
// Depends on bgb_pkg and the blitter RTL.

module tb_top;
	import bgb_pkg::*;

	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 48;

	typedef struct {
		logic               op;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [7:0]         char_code;
		logic [15:0]        color;
		logic [10:0]        font_row_index;
		logic [7:0]         font_row_bits;
	} glyph_cmd_t;

	typedef struct {
		logic signed [12:0] row;
		logic signed [12:0] col;
		logic [15:0]        value;
		logic               last;
	} pixel_write_t;

	// known_n < 0 means the pixel writes come from the predictor.
	typedef struct {
		glyph_cmd_t   cmd;
		int           known_n;
		pixel_write_t known;
	} stim_row_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                operation      = OP_DRAW;
	logic signed [11:0]  pos_x          = '0;
	logic signed [11:0]  pos_y          = '0;
	logic [7:0]          char_code      = '0;
	logic [15:0]         color          = '0;
	logic [10:0]         font_row_index = '0;
	logic [7:0]          font_row_bits  = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic signed [12:0]  pixel_row;
	logic signed [12:0]  pixel_column;
	logic [15:0]         pixel_value;
	logic                last;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [2:0]          cfg_index      = '0;
	logic [10:0]         cfg_data       = '0;

	// Mirror of the font store, the registers and the pixel writes still to come.
	logic [7:0]   font_copy [STORE_DEPTH];
	logic [7:0]   rows_loaded [GLYPH_COUNT];
	logic [7:0]   drawable[$];
	cfg_t         regs;
	pixel_write_t pixels_due[$];
	pixel_write_t head_px;
	pixel_write_t blank_px;
	stim_row_t    directed[$];

	bit gaps_on        = 1'b1;
	int mismatches     = 0;
	int writes_checked = 0;
	int draws_sent     = 0;
	int font_rows_sent = 0;
	int phases_run     = 0;
	int quiet          = 0;

	bitmap_glyph_blitter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.char_code      (char_code),
		.color          (color),
		.font_row_index (font_row_index),
		.font_row_bits  (font_row_bits),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_row      (pixel_row),
		.pixel_column   (pixel_column),
		.pixel_value    (pixel_value),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	// Updates the font mirror for a row write, or appends the pixel writes of a draw.
	function automatic void track_item(input glyph_cmd_t c, input bit queue_it);
		int x;
		int y;
		int n;
		logic [7:0] bits;
		pixel_write_t p;
		logic [7:0] g;
		x = c.pos_x;
		y = c.pos_y;
		n = 0;
		g = c.font_row_index[10:3];
		if (c.op == OP_FONT_ROW) begin
			font_copy[c.font_row_index] = c.font_row_bits;
			if (!(&rows_loaded[g])) begin
				rows_loaded[g][c.font_row_index[2:0]] = 1'b1;
				if (&rows_loaded[g])
					drawable.push_back(g);
			end
			return;
		end
		if (x > int'(regs.clip_right) || y > int'(regs.clip_bottom))
			return;
		if (x + GLYPH_WIDTH - 1 < int'(regs.clip_left) ||
		    y + GLYPH_HEIGHT - 1 < int'(regs.clip_top))
			return;
		for (int r = 0; r < GLYPH_HEIGHT; r++) begin
			bits = font_copy[{c.char_code, 3'(r)}];
			for (int k = 0; k < GLYPH_WIDTH; k++) begin
				if (bits[7 - k]) begin
					p.row   = 13'(y + r + int'(regs.back_buffer_row));
					p.col   = 13'(x + k);
					p.value = regs.wide_pixels ? c.color : {8'h00, c.color[7:0]};
					p.last  = 1'b0;
					if (queue_it)
						pixels_due.push_back(p);
					n++;
				end
			end
		end
		if (queue_it && n > 0)
			pixels_due[pixels_due.size() - 1].last = 1'b1;
	endfunction

	function automatic glyph_cmd_t noise_cmd();
		glyph_cmd_t c;
		c.op             = OP_DRAW;
		c.pos_x          = 12'($urandom);
		c.pos_y          = 12'($urandom);
		c.char_code      = 8'($urandom);
		c.color          = 16'($urandom);
		c.font_row_index = 11'($urandom);
		c.font_row_bits  = 8'($urandom);
		return c;
	endfunction

	function automatic glyph_cmd_t font_row(input logic [10:0] idx, input logic [7:0] bits);
		glyph_cmd_t c;
		c = '{OP_FONT_ROW, 12'sd0, 12'sd0, 8'd0, 16'd0, idx, bits};
		return c;
	endfunction

	function automatic glyph_cmd_t draw_at(input int x, input int y, input logic [7:0] ch,
	                                       input logic [15:0] col);
		glyph_cmd_t c;
		c = '{OP_DRAW, 12'(x), 12'(y), ch, col, 11'd0, 8'd0};
		return c;
	endfunction

	function automatic pixel_write_t lone_px(input int r, input int cl, input logic [15:0] v);
		pixel_write_t p;
		p = '{13'(r), 13'(cl), v, 1'b1};
		return p;
	endfunction

	function automatic logic [7:0] pattern_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly lands around the clip window so that edge hits and misses both occur.
	function automatic logic signed [11:0] near_span(input int lo, input int hi);
		int a;
		int b;
		int v;
		a = (lo < hi ? lo : hi) - 12;
		b = (lo < hi ? hi : lo) + 12;
		if ($urandom_range(4) == 0)
			return 12'($urandom);
		v = a + int'($urandom_range(b - a));
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return 12'(v);
	endfunction

	task automatic offer_item(input glyph_cmd_t c, input int known_n, input pixel_write_t known);
		while (gaps_on && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= c.op;
		pos_x          <= c.pos_x;
		pos_y          <= c.pos_y;
		char_code      <= c.char_code;
		color          <= c.color;
		font_row_index <= c.font_row_index;
		font_row_bits  <= c.font_row_bits;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_item(c, known_n < 0);
		if (known_n == 1)
			pixels_due.push_back(known);
		if (c.op == OP_FONT_ROW)
			font_rows_sent++;
		else
			draws_sent++;
	endtask

	// An empty or clipped draw gives no pixel writes, and an empty draw may still keep the block busy.
	task automatic settle();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_CLIP_LEFT:   regs.clip_left       = data;
			REG_CLIP_TOP:    regs.clip_top        = data;
			REG_CLIP_RIGHT:  regs.clip_right      = data;
			REG_CLIP_BOTTOM: regs.clip_bottom     = data;
			REG_WIDE_PIXELS: regs.wide_pixels     = data[0];
			REG_BACK_ROW:    regs.back_buffer_row = data;
			default: ;
		endcase
	endtask

	task automatic load_window(input cfg_t w);
		write_reg(REG_CLIP_LEFT, w.clip_left);
		write_reg(REG_CLIP_TOP, w.clip_top);
		write_reg(REG_CLIP_RIGHT, w.clip_right);
		write_reg(REG_CLIP_BOTTOM, w.clip_bottom);
		write_reg(REG_WIDE_PIXELS, {10'd0, w.wide_pixels});
		write_reg(REG_BACK_ROW, w.back_buffer_row);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					$error("pixel write with none pending: row %0d column %0d",
					       pixel_row, pixel_column);
					mismatches++;
				end else begin
					head_px = pixels_due.pop_front();
					if (pixel_row !== head_px.row) begin
						$error("pixel_row: expected %0d, got %0d", head_px.row, pixel_row);
						mismatches++;
					end
					if (pixel_column !== head_px.col) begin
						$error("pixel_column: expected %0d, got %0d", head_px.col, pixel_column);
						mismatches++;
					end
					if (pixel_value !== head_px.value) begin
						$error("pixel_value: expected %h, got %h", head_px.value, pixel_value);
						mismatches++;
					end
					if (last !== head_px.last) begin
						$error("last: expected %b, got %b", head_px.last, last);
						mismatches++;
					end
					writes_checked++;
				end
			end
			out_ready <= gaps_on ? ($urandom_range(99) >= 6) : 1'b1;
		end
	end

	// Any transfer on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else if (quiet >= QUIET_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	initial begin
		cfg_t       windows [5];
		glyph_cmd_t c;
		int         quota;
		int         pick;
		logic [7:0] g;

		blank_px = '{default: '0};
		for (int i = 0; i < GLYPH_COUNT; i++)
			rows_loaded[i] = '0;
		regs = '{clip_left: 11'd0, clip_top: 11'd0, clip_right: 11'd639,
		         clip_bottom: 11'd479, wide_pixels: 1'b1, back_buffer_row: 11'd0};

		windows[0] = '{clip_left: 11'd0, clip_top: 11'd0, clip_right: 11'd2047,
		               clip_bottom: 11'd2047, wide_pixels: 1'b1, back_buffer_row: 11'd0};
		// Large row offset wraps the 13-bit row near the bottom of the frame.
		windows[1] = '{clip_left: 11'd0, clip_top: 11'd0, clip_right: 11'd2047,
		               clip_bottom: 11'd2047, wide_pixels: 1'b0, back_buffer_row: 11'd2047};
		// Inverted window: left past right and top past bottom.
		windows[2] = '{clip_left: 11'd205, clip_top: 11'd104, clip_right: 11'd200,
		               clip_bottom: 11'd100, wide_pixels: 1'b1, back_buffer_row: 11'd1000};
		windows[3] = '{clip_left: 11'd0, clip_top: 11'd0, clip_right: 11'd0,
		               clip_bottom: 11'd0, wide_pixels: 1'b0, back_buffer_row: 11'd0};
		windows[4] = '{clip_left: 11'd2047, clip_top: 11'd2047, clip_right: 11'd2047,
		               clip_bottom: 11'd2047, wide_pixels: 1'b1, back_buffer_row: 11'd2047};

		// Glyph 0 is left empty; glyph 255 holds only its top-left pixel.
		for (int r = 0; r < 8; r++)
			directed.push_back('{font_row(11'(r), 8'h00), 0, blank_px});
		for (int r = 0; r < 8; r++)
			directed.push_back('{font_row(11'(2040 + r), (r == 0) ? 8'h80 : 8'h00), 0, blank_px});
		directed.push_back('{draw_at(0, 0, 8'd255, 16'hFFFF), 1, lone_px(0, 0, 16'hFFFF)});
		directed.push_back('{draw_at(100, 100, 8'd0, 16'h5A5A), 0, blank_px});
		directed.push_back('{draw_at(640, 0, 8'd255, 16'h1111), 0, blank_px});
		directed.push_back('{draw_at(0, 480, 8'd255, 16'h2222), 0, blank_px});
		directed.push_back('{draw_at(-8, 0, 8'd255, 16'h3333), 0, blank_px});
		// A cell that overlaps the window by one column and one row is drawn whole.
		directed.push_back('{draw_at(-7, -7, 8'd255, 16'h0000), 1, lone_px(-7, -7, 16'h0000)});
		directed.push_back('{draw_at(639, 479, 8'd255, 16'h1234), 1, lone_px(479, 639, 16'h1234)});
		directed.push_back('{draw_at(-2048, -2048, 8'd255, 16'hFFFF), 0, blank_px});
		directed.push_back('{draw_at(2047, 2047, 8'd255, 16'hFFFF), 0, blank_px});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_item(directed[i].cmd, directed[i].known_n, directed[i].known);
		settle();

		foreach (windows[p]) begin
			gaps_on = (p != 1);
			load_window(windows[p]);
			phases_run++;
			quota = font_rows_sent + draws_sent + PHASE_ITEMS;
			while (font_rows_sent + draws_sent < quota) begin
				pick = $urandom_range(99);
				c = noise_cmd();
				if (pick < 10) begin
					// Fill all eight rows of one glyph so that it can be drawn.
					g = 8'($urandom);
					for (int r = 0; r < 8; r++) begin
						c = noise_cmd();
						c.op             = OP_FONT_ROW;
						c.font_row_index = {g, 3'(r)};
						c.font_row_bits  = pattern_byte();
						offer_item(c, -1, blank_px);
					end
				end else if (pick < 18) begin
					c.op            = OP_FONT_ROW;
					c.font_row_bits = pattern_byte();
					offer_item(c, -1, blank_px);
				end else begin
					c.char_code = drawable[$urandom_range(drawable.size() - 1)];
					c.pos_x     = near_span(windows[p].clip_left, windows[p].clip_right);
					c.pos_y     = near_span(windows[p].clip_top, windows[p].clip_bottom);
					case ($urandom_range(9))
						0: c.color = 16'h0000;
						1: c.color = 16'hFFFF;
						default: ;
					endcase
					offer_item(c, -1, blank_px);
				end
			end
			settle();
		end

		$display("Checked %0d pixel writes from %0d glyph draws and %0d font-row transfers,",
		         writes_checked, draws_sent, font_rows_sent);
		$display("under the reset window and %0d programmed clip settings.", phases_run);
		if (pixels_due.size() != 0) begin
			$error("%0d pixel writes never arrived", pixels_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bgb_pkg.sv
hw/rtl/bgb_font_mem.sv
hw/rtl/bgb_sequencer.sv
hw/rtl/bgb_datapath.sv
hw/rtl/bitmap_glyph_blitter.sv
tb/sv/tb_top.sv
